// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file stt_checker.sv
// depends on nothing; each macro expands to one labelled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every edge outside reset
`define STT_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent that must hold in the cycle after the antecedent
`define STT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/stt_pkg.sv =====
// types, token codes and lookup functions of the source text tokenizer
// depends on nothing
package stt_pkg;

    localparam int LINE_BITS = 16;
    localparam int COLUMN_BITS = 12;
    localparam int WORD_BUFFER_DEPTH = 12;
    localparam int MAX_RES = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int KW_COUNT = 16;
    localparam int KW_BYTES = 11;

    localparam logic [1:0] REC_CONTENT = 2'd0;
    localparam logic [1:0] REC_TOKEN = 2'd1;
    localparam logic [1:0] REC_ERROR = 2'd2;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_STRING = 2'd1;
    localparam logic [1:0] ERR_CHAR = 2'd2;
    localparam logic [1:0] ERR_UNEXPECTED = 2'd3;

    localparam logic [5:0] TK_INT = 6'd9;
    localparam logic [5:0] TK_FLOAT = 6'd10;
    localparam logic [5:0] TK_CHAR = 6'd11;
    localparam logic [5:0] TK_INT_ARRAY = 6'd13;
    localparam logic [5:0] TK_NUMBER = 6'd19;
    localparam logic [5:0] TK_DECIMAL = 6'd20;
    localparam logic [5:0] TK_CHAR_LIT = 6'd21;
    localparam logic [5:0] TK_STRING_LIT = 6'd22;
    localparam logic [5:0] TK_IDENT = 6'd23;
    localparam logic [5:0] TK_LBRACKET = 6'd44;
    localparam logic [5:0] TK_END = 6'd50;
    localparam logic [5:0] TK_NONE = 6'd63;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_source;
    } in_item_t;

    typedef struct packed {
        logic [1:0]             record_kind;
        logic [5:0]             token_kind;
        logic [7:0]             text_byte;
        logic [LINE_BITS-1:0]   token_line;
        logic [COLUMN_BITS-1:0] token_column;
        logic [1:0]             error_code;
        logic                   last_of_run;
    } out_rec_t;

    typedef struct packed {
        logic [2:0]                  count;
        out_rec_t [MAX_RES-1:0]      recs;
    } bundle_t;

    // keyword text, right aligned, first character in the highest used byte
    localparam logic [8*KW_BYTES-1:0] KW_TEXT [KW_COUNT] = '{
        88'("polamanna"), 88'("niruthuanna"), 88'("Op"), 88'("sollu"),
        88'("if"), 88'("elif"), 88'("else"), 88'("while"),
        88'("main"), 88'("int"), 88'("float"), 88'("char"),
        88'("string"), 88'("LHS"), 88'("RHS"), 88'("operator")};
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd9, 4'd11, 4'd2, 4'd5, 4'd2, 4'd4, 4'd4, 4'd5,
        4'd4, 4'd3, 4'd5, 4'd4, 4'd6, 4'd3, 4'd3, 4'd8};
    localparam logic [5:0] KW_CODE [KW_COUNT] = '{
        6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7,
        6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd16, 6'd17, 6'd18};

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == "_");
    endfunction

    // w holds the first word bytes, byte 0 in the lowest bits
    function automatic logic [5:0] word_code(input logic [8*KW_BYTES-1:0] w,
                                             input logic [4:0] len);
        logic [5:0] code;
        logic       hit;
        code = TK_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            hit = (len == {1'b0, KW_LEN[k]});
            for (int i = 0; i < KW_BYTES; i++) begin
                if ((4'(i) < KW_LEN[k]) &&
                    (w[8*i +: 8] != KW_TEXT[k][8*(int'(KW_LEN[k]) - 1 - i) +: 8]))
                    hit = 1'b0;
            end
            if (hit)
                code = KW_CODE[k];
        end
        return code;
    endfunction

    function automatic logic [5:0] single_code(input logic [7:0] c);
        logic [5:0] k;
        case (c)
            "+": k = 6'd24;
            "-": k = 6'd25;
            "*": k = 6'd26;
            "/": k = 6'd27;
            "%": k = 6'd28;
            "!": k = 6'd29;
            "<": k = 6'd30;
            ">": k = 6'd31;
            "=": k = 6'd38;
            "(": k = 6'd40;
            ")": k = 6'd41;
            "[": k = 6'd44;
            "]": k = 6'd45;
            "{": k = 6'd42;
            "}": k = 6'd43;
            ",": k = 6'd46;
            ";": k = 6'd47;
            ":": k = 6'd48;
            "^": k = 6'd49;
            default: k = TK_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] pair_code(input logic [7:0] h, input logic [7:0] c);
        logic [5:0] k;
        k = TK_NONE;
        if (c == "=") begin
            case (h)
                "<": k = 6'd32;
                ">": k = 6'd33;
                "=": k = 6'd34;
                "!": k = 6'd35;
                ":": k = 6'd39;
                default: k = TK_NONE;
            endcase
        end
        if ((h == "&") && (c == "&"))
            k = 6'd36;
        if ((h == "|") && (c == "|"))
            k = 6'd37;
        return k;
    endfunction

    function automatic logic [7:0] esc_value(input logic [7:0] c);
        logic [7:0] v;
        case (c)
            "n": v = 8'h0a;
            "t": v = 8'h09;
            default: v = c;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/stt_front.sv =====
// scanner front end: takes one source byte a cycle while take is high and builds its bundle of records
// depends on stt_pkg
module stt_front #(
    parameter int WORD_BUFFER_DEPTH = stt_pkg::WORD_BUFFER_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  stt_pkg::in_item_t item,
    output logic              bundle_valid,
    output stt_pkg::bundle_t  bundle
);

    localparam int LEN_W = $clog2(WORD_BUFFER_DEPTH + 1);
    localparam int IDX_W = $clog2(WORD_BUFFER_DEPTH);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(WORD_BUFFER_DEPTH);

    localparam logic [3:0] M_IDLE = 4'd0;
    localparam logic [3:0] M_WORD = 4'd1;
    localparam logic [3:0] M_WORDBR = 4'd2;
    localparam logic [3:0] M_NUM = 4'd3;
    localparam logic [3:0] M_NUMDOT = 4'd4;
    localparam logic [3:0] M_DEC = 4'd5;
    localparam logic [3:0] M_STR = 4'd6;
    localparam logic [3:0] M_STRESC = 4'd7;
    localparam logic [3:0] M_CHOPEN = 4'd8;
    localparam logic [3:0] M_CHESC = 4'd9;
    localparam logic [3:0] M_CHCLOSE = 4'd10;
    localparam logic [3:0] M_OP = 4'd11;
    localparam logic [3:0] M_COMMENT = 4'd12;
    localparam logic [3:0] M_HALT = 4'd13;

    localparam logic [stt_pkg::LINE_BITS-1:0] LINE_ONE = stt_pkg::LINE_BITS'(1);
    localparam logic [stt_pkg::COLUMN_BITS-1:0] COL_ONE = stt_pkg::COLUMN_BITS'(1);

    logic [3:0]                        mode_reg, mode_next;
    logic [7:0]                        held_reg, held_next;
    logic [LEN_W-1:0]                  len_reg, len_next;
    logic [stt_pkg::LINE_BITS-1:0]     line_reg, line_next;
    logic [stt_pkg::COLUMN_BITS-1:0]   col_reg, col_next;
    logic [stt_pkg::COLUMN_BITS-1:0]   start_reg, start_next;
    logic [stt_pkg::COLUMN_BITS-1:0]   hcol_reg, hcol_next;
    logic [7:0]                        buf_reg [WORD_BUFFER_DEPTH];

    logic                              buf_we;
    logic [IDX_W-1:0]                  buf_idx;
    logic [7:0]                        c;
    logic [8*stt_pkg::KW_BYTES-1:0]    word_bytes;
    logic [5:0]                        wcode, acode, k;
    logic                              arr_ok;

    // fresh start of a token on the current byte
    logic [3:0]                        f_mode;
    logic                              f_start, f_word, f_held, f_rec_v;
    stt_pkg::out_rec_t                 f_rec;

    stt_pkg::out_rec_t [stt_pkg::MAX_RES-1:0] recs;
    logic [2:0]                        n;
    logic                              do_fresh, halted;

    function automatic stt_pkg::out_rec_t mk(
        input logic [1:0] rk, input logic [5:0] tk, input logic [7:0] b,
        input logic [1:0] err, input logic [stt_pkg::LINE_BITS-1:0] ln,
        input logic [stt_pkg::COLUMN_BITS-1:0] col);
        stt_pkg::out_rec_t r;
        r.record_kind = rk;
        r.token_kind = tk;
        r.text_byte = b;
        r.token_line = ln;
        r.token_column = col;
        r.error_code = err;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    assign c = item.char_code;

    always_comb
    begin
        for (int i = 0; i < stt_pkg::KW_BYTES; i++)
            word_bytes[8*i +: 8] = buf_reg[i];
    end

    assign wcode = stt_pkg::word_code(word_bytes, 5'(len_reg));
    assign arr_ok = (wcode == stt_pkg::TK_INT) || (wcode == stt_pkg::TK_FLOAT) ||
                    (wcode == stt_pkg::TK_CHAR);
    assign acode = wcode + (stt_pkg::TK_INT_ARRAY - stt_pkg::TK_INT);

    always_comb
    begin
        f_mode = M_IDLE;
        f_start = 1'b0;
        f_word = 1'b0;
        f_held = 1'b0;
        f_rec_v = 1'b0;
        f_rec = mk(stt_pkg::REC_CONTENT, 6'd0, c, stt_pkg::ERR_NONE, line_reg, col_reg);
        if (!((c == " ") || (c == 8'h09) || (c == 8'h0d) || (c == 8'h0a))) begin
            f_start = 1'b1;
            if (stt_pkg::is_digit(c)) begin
                f_mode = M_NUM;
                f_rec_v = 1'b1;
            end else if (c == "\"") begin
                f_mode = M_STR;
            end else if (c == "'") begin
                f_mode = M_CHOPEN;
            end else if (stt_pkg::is_alpha(c) || (c == "_")) begin
                f_mode = M_WORD;
                f_word = 1'b1;
                f_rec_v = 1'b1;
            end else if ((c == "<") || (c == ">") || (c == "=") || (c == "!") ||
                         (c == "&") || (c == "|") || (c == ":") || (c == "/")) begin
                f_mode = M_OP;
                f_held = 1'b1;
            end else if (stt_pkg::single_code(c) != stt_pkg::TK_NONE) begin
                f_rec_v = 1'b1;
                f_rec = mk(stt_pkg::REC_TOKEN, stt_pkg::single_code(c), 8'd0,
                           stt_pkg::ERR_NONE, line_reg, col_reg);
            end else begin
                f_mode = M_HALT;
                f_rec_v = 1'b1;
                f_rec = mk(stt_pkg::REC_ERROR, 6'd0, c, stt_pkg::ERR_UNEXPECTED,
                           line_reg, col_reg);
            end
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        held_next = held_reg;
        len_next = len_reg;
        line_next = line_reg;
        col_next = col_reg;
        start_next = start_reg;
        hcol_next = hcol_reg;
        buf_we = 1'b0;
        buf_idx = len_reg[IDX_W-1:0];
        recs = '0;
        n = 3'd0;
        do_fresh = 1'b0;
        halted = 1'b0;
        k = stt_pkg::single_code(held_reg);

        if (item.end_of_source) begin
            if (mode_reg != M_HALT) begin
                unique case (mode_reg) inside
                    M_WORD:
                    begin
                        recs[n[1:0]] = mk(stt_pkg::REC_TOKEN, wcode, 8'd0, stt_pkg::ERR_NONE,
                                          line_reg, start_reg);
                        n = n + 3'd1;
                    end
                    M_WORDBR:
                    begin
                        recs[n[1:0]] = mk(stt_pkg::REC_TOKEN, wcode, 8'd0, stt_pkg::ERR_NONE,
                                          line_reg, start_reg);
                        n = n + 3'd1;
                        recs[n[1:0]] = mk(stt_pkg::REC_TOKEN, stt_pkg::TK_LBRACKET, 8'd0,
                                          stt_pkg::ERR_NONE, line_reg, hcol_reg);
                        n = n + 3'd1;
                    end
                    M_NUM:
                    begin
                        recs[n[1:0]] = mk(stt_pkg::REC_TOKEN, stt_pkg::TK_NUMBER, 8'd0,
                                          stt_pkg::ERR_NONE, line_reg, start_reg);
                        n = n + 3'd1;
                    end
                    M_NUMDOT:
                    begin
                        recs[n[1:0]] = mk(stt_pkg::REC_TOKEN, stt_pkg::TK_NUMBER, 8'd0,
                                          stt_pkg::ERR_NONE, line_reg, start_reg);
                        n = n + 3'd1;
                        recs[n[1:0]] = mk(stt_pkg::REC_ERROR, 6'd0, ".",
                                          stt_pkg::ERR_UNEXPECTED, line_reg, hcol_reg);
                        n = n + 3'd1;
                        halted = 1'b1;
                    end
                    M_DEC:
                    begin
                        recs[n[1:0]] = mk(stt_pkg::REC_TOKEN, stt_pkg::TK_DECIMAL, 8'd0,
                                          stt_pkg::ERR_NONE, line_reg, start_reg);
                        n = n + 3'd1;
                    end
                    M_STR, M_STRESC:
                    begin
                        recs[n[1:0]] = mk(stt_pkg::REC_ERROR, 6'd0, 8'd0, stt_pkg::ERR_STRING,
                                          line_reg, col_reg);
                        n = n + 3'd1;
                        halted = 1'b1;
                    end
                    M_CHOPEN, M_CHESC, M_CHCLOSE:
                    begin
                        recs[n[1:0]] = mk(stt_pkg::REC_ERROR, 6'd0, 8'd0, stt_pkg::ERR_CHAR,
                                          line_reg, col_reg);
                        n = n + 3'd1;
                        halted = 1'b1;
                    end
                    M_OP:
                    begin
                        if (k == stt_pkg::TK_NONE) begin
                            recs[n[1:0]] = mk(stt_pkg::REC_ERROR, 6'd0, held_reg,
                                              stt_pkg::ERR_UNEXPECTED, line_reg, start_reg);
                            halted = 1'b1;
                        end else begin
                            recs[n[1:0]] = mk(stt_pkg::REC_TOKEN, k, 8'd0, stt_pkg::ERR_NONE,
                                              line_reg, start_reg);
                        end
                        n = n + 3'd1;
                    end
                    default:
                    begin
                    end
                endcase
                if (!halted) begin
                    recs[n[1:0]] = mk(stt_pkg::REC_TOKEN, stt_pkg::TK_END, 8'd0,
                                      stt_pkg::ERR_NONE, line_reg, col_reg);
                    n = n + 3'd1;
                end
            end
            // back to the reset state
            mode_next = M_IDLE;
            held_next = 8'd0;
            len_next = '0;
            line_next = LINE_ONE;
            col_next = COL_ONE;
            start_next = COL_ONE;
            hcol_next = COL_ONE;
        end else begin
            unique case (mode_reg) inside
                M_HALT:
                begin
                end
                M_COMMENT:
                begin
                    if (c == 8'h0a)
                        mode_next = M_IDLE;
                end
                M_IDLE:
                    do_fresh = 1'b1;
                M_WORD:
                begin
                    if (stt_pkg::is_word(c)) begin
                        if (len_reg < LEN_MAX) begin
                            buf_we = 1'b1;
                            len_next = len_reg + LEN_W'(1);
                        end
                        recs[n[1:0]] = mk(stt_pkg::REC_CONTENT, 6'd0, c, stt_pkg::ERR_NONE,
                                          line_reg, start_reg);
                        n = n + 3'd1;
                    end else if ((c == "[") && arr_ok) begin
                        hcol_next = col_reg;
                        mode_next = M_WORDBR;
                    end else begin
                        recs[n[1:0]] = mk(stt_pkg::REC_TOKEN, wcode, 8'd0, stt_pkg::ERR_NONE,
                                          line_reg, start_reg);
                        n = n + 3'd1;
                        do_fresh = 1'b1;
                    end
                end
                M_WORDBR:
                begin
                    if (c == "]") begin
                        recs[0] = mk(stt_pkg::REC_CONTENT, 6'd0, "[", stt_pkg::ERR_NONE,
                                     line_reg, start_reg);
                        recs[1] = mk(stt_pkg::REC_CONTENT, 6'd0, "]", stt_pkg::ERR_NONE,
                                     line_reg, start_reg);
                        recs[2] = mk(stt_pkg::REC_TOKEN, acode, 8'd0, stt_pkg::ERR_NONE,
                                     line_reg, start_reg);
                        n = 3'd3;
                        mode_next = M_IDLE;
                    end else begin
                        recs[0] = mk(stt_pkg::REC_TOKEN, wcode, 8'd0, stt_pkg::ERR_NONE,
                                     line_reg, start_reg);
                        recs[1] = mk(stt_pkg::REC_TOKEN, stt_pkg::TK_LBRACKET, 8'd0,
                                     stt_pkg::ERR_NONE, line_reg, hcol_reg);
                        n = 3'd2;
                        do_fresh = 1'b1;
                    end
                end
                M_NUM, M_DEC:
                begin
                    if (stt_pkg::is_digit(c)) begin
                        recs[0] = mk(stt_pkg::REC_CONTENT, 6'd0, c, stt_pkg::ERR_NONE,
                                     line_reg, start_reg);
                        n = 3'd1;
                    end else if ((mode_reg == M_NUM) && (c == ".")) begin
                        hcol_next = col_reg;
                        mode_next = M_NUMDOT;
                    end else begin
                        recs[0] = mk(stt_pkg::REC_TOKEN,
                                     (mode_reg == M_NUM) ? stt_pkg::TK_NUMBER
                                                         : stt_pkg::TK_DECIMAL,
                                     8'd0, stt_pkg::ERR_NONE, line_reg, start_reg);
                        n = 3'd1;
                        do_fresh = 1'b1;
                    end
                end
                M_NUMDOT:
                begin
                    if (stt_pkg::is_digit(c)) begin
                        recs[0] = mk(stt_pkg::REC_CONTENT, 6'd0, ".", stt_pkg::ERR_NONE,
                                     line_reg, start_reg);
                        recs[1] = mk(stt_pkg::REC_CONTENT, 6'd0, c, stt_pkg::ERR_NONE,
                                     line_reg, start_reg);
                        mode_next = M_DEC;
                    end else begin
                        recs[0] = mk(stt_pkg::REC_TOKEN, stt_pkg::TK_NUMBER, 8'd0,
                                     stt_pkg::ERR_NONE, line_reg, start_reg);
                        recs[1] = mk(stt_pkg::REC_ERROR, 6'd0, ".", stt_pkg::ERR_UNEXPECTED,
                                     line_reg, hcol_reg);
                        mode_next = M_HALT;
                    end
                    n = 3'd2;
                end
                M_STR:
                begin
                    if (c == "\"") begin
                        recs[0] = mk(stt_pkg::REC_TOKEN, stt_pkg::TK_STRING_LIT, 8'd0,
                                     stt_pkg::ERR_NONE, line_reg, start_reg);
                        n = 3'd1;
                        mode_next = M_IDLE;
                    end else if (c == "\\") begin
                        mode_next = M_STRESC;
                    end else begin
                        recs[0] = mk(stt_pkg::REC_CONTENT, 6'd0, c, stt_pkg::ERR_NONE,
                                     line_reg, start_reg);
                        n = 3'd1;
                    end
                end
                M_STRESC, M_CHESC:
                begin
                    recs[0] = mk(stt_pkg::REC_CONTENT, 6'd0, stt_pkg::esc_value(c),
                                 stt_pkg::ERR_NONE, line_reg, start_reg);
                    n = 3'd1;
                    mode_next = (mode_reg == M_STRESC) ? M_STR : M_CHCLOSE;
                end
                M_CHOPEN:
                begin
                    if (c == "\\") begin
                        mode_next = M_CHESC;
                    end else begin
                        recs[0] = mk(stt_pkg::REC_CONTENT, 6'd0, c, stt_pkg::ERR_NONE,
                                     line_reg, start_reg);
                        n = 3'd1;
                        mode_next = M_CHCLOSE;
                    end
                end
                M_CHCLOSE:
                begin
                    if (c == "'") begin
                        recs[0] = mk(stt_pkg::REC_TOKEN, stt_pkg::TK_CHAR_LIT, 8'd0,
                                     stt_pkg::ERR_NONE, line_reg, start_reg);
                        mode_next = M_IDLE;
                    end else begin
                        recs[0] = mk(stt_pkg::REC_ERROR, 6'd0, 8'd0, stt_pkg::ERR_CHAR,
                                     line_reg, col_reg);
                        mode_next = M_HALT;
                    end
                    n = 3'd1;
                end
                M_OP:
                begin
                    if (stt_pkg::pair_code(held_reg, c) != stt_pkg::TK_NONE) begin
                        recs[0] = mk(stt_pkg::REC_TOKEN, stt_pkg::pair_code(held_reg, c),
                                     8'd0, stt_pkg::ERR_NONE, line_reg, start_reg);
                        n = 3'd1;
                        mode_next = M_IDLE;
                    end else if ((held_reg == "/") && (c == "/")) begin
                        mode_next = M_COMMENT;
                    end else if (k == stt_pkg::TK_NONE) begin
                        recs[0] = mk(stt_pkg::REC_ERROR, 6'd0, held_reg,
                                     stt_pkg::ERR_UNEXPECTED, line_reg, start_reg);
                        n = 3'd1;
                        mode_next = M_HALT;
                    end else begin
                        recs[0] = mk(stt_pkg::REC_TOKEN, k, 8'd0, stt_pkg::ERR_NONE,
                                     line_reg, start_reg);
                        n = 3'd1;
                        do_fresh = 1'b1;
                    end
                end
                default:
                    mode_next = M_IDLE;
            endcase

            if (do_fresh) begin
                mode_next = f_mode;
                if (f_start)
                    start_next = col_reg;
                if (f_word) begin
                    buf_we = 1'b1;
                    buf_idx = '0;
                    len_next = LEN_W'(1);
                end
                if (f_held)
                    held_next = c;
                if (f_rec_v) begin
                    recs[n[1:0]] = f_rec;
                    n = n + 3'd1;
                end
            end

            // line and column move on every byte, saturating
            if (c == 8'h0a) begin
                if (line_reg != '1)
                    line_next = line_reg + LINE_ONE;
                col_next = COL_ONE;
            end else if (col_reg != '1) begin
                col_next = col_reg + COL_ONE;
            end
        end
    end

    assign bundle_valid = take && (n != 3'd0);
    assign bundle.count = n;
    assign bundle.recs = recs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= M_IDLE;
            held_reg <= 8'd0;
            len_reg <= '0;
            line_reg <= LINE_ONE;
            col_reg <= COL_ONE;
            start_reg <= COL_ONE;
            hcol_reg <= COL_ONE;
        end else if (take) begin
            mode_reg <= mode_next;
            held_reg <= held_next;
            len_reg <= len_next;
            line_reg <= line_next;
            col_reg <= col_next;
            start_reg <= start_next;
            hcol_reg <= hcol_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && buf_we)
            buf_reg[buf_idx] <= c;
    end

endmodule

// ===== rtl/stt_queue.sv =====
// short queue of record bundles between scanner and output side
// depends on stt_pkg
module stt_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  stt_pkg::bundle_t wr_data,
    output logic             is_full,
    input  logic             rd_en,
    output logic             rd_valid,
    output stt_pkg::bundle_t rd_data
);

    localparam int PTR_W = $clog2(stt_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(stt_pkg::QUEUE_DEPTH + 1);

    stt_pkg::bundle_t   slot_reg [stt_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_wr, do_rd;

    assign is_full = (cnt_reg == CNT_W'(stt_pkg::QUEUE_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data = slot_reg[rd_ptr_reg];
    assign do_wr = wr_en && !is_full;
    assign do_rd = rd_en && rd_valid;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== rtl/stt_back.sv =====
// output side: unpacks one bundle at a time into single records
// depends on stt_pkg
module stt_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  stt_pkg::bundle_t  q_data,
    output logic              q_pop,
    input  logic              pop,
    output logic              empty,
    output stt_pkg::out_rec_t result
);

    logic               hold_reg;
    stt_pkg::bundle_t   bund_reg;
    logic [1:0]         idx_reg;
    logic               fire, last, load;

    assign empty = !hold_reg;
    assign fire = pop && hold_reg;
    assign last = ({1'b0, idx_reg} == (bund_reg.count - 3'd1));
    assign load = !hold_reg || (fire && last);
    assign q_pop = load && q_valid;

    always_comb
    begin
        result = bund_reg.recs[idx_reg];
        result.last_of_run = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hold_reg <= 1'b0;
            idx_reg <= 2'd0;
        end else if (load) begin
            hold_reg <= q_valid;
            idx_reg <= 2'd0;
        end else if (fire) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            bund_reg <= q_data;
    end

endmodule

// ===== rtl/source_text_tokenizer.sv =====
// top level of the source text tokenizer: scanner, bundle queue, output side
// depends on stt_pkg, stt_front, stt_queue, stt_back
//
// channel   direction  handshake            payload
// input     in         push / full          source_item (char_code, end_of_source)
// results   out        pop / empty          result (one record)
//
// one source byte is taken every cycle while push is high and the bundle queue has room
// each byte yields zero to three records; the output side sends one record a cycle while pop is high
// the records of a taken byte are registered in the bundle queue and then in the output side before the first shows
// full rises only when four bundles wait; reset is asynchronous and clears all control state
module source_text_tokenizer #(
    parameter int WORD_BUFFER_DEPTH = stt_pkg::WORD_BUFFER_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  stt_pkg::in_item_t source_item,
    input  logic              pop,
    output logic              empty,
    output stt_pkg::out_rec_t result
);

    logic             take, b_valid, q_valid, q_pop;
    stt_pkg::bundle_t b_data, q_data;

    assign take = push && !full;

    stt_front #(
        .WORD_BUFFER_DEPTH(WORD_BUFFER_DEPTH)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .take(take),
        .item(source_item),
        .bundle_valid(b_valid),
        .bundle(b_data)
    );

    stt_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .wr_en(b_valid),
        .wr_data(b_data),
        .is_full(full),
        .rd_en(q_pop),
        .rd_valid(q_valid),
        .rd_data(q_data)
    );

    stt_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .q_valid(q_valid),
        .q_data(q_data),
        .q_pop(q_pop),
        .pop(pop),
        .empty(empty),
        .result(result)
    );

endmodule

// ===== rtl/stt_checker.sv =====
// port level checks on the source text tokenizer, bound to the top level
// depends on stt_pkg and assert_macros.svh
`include "assert_macros.svh"

module stt_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              pop,
    input logic              empty,
    input stt_pkg::out_rec_t result
);

    logic shown, is_err, has_code, kind_ok;

    assign shown = !empty;
    assign is_err = (result.record_kind == stt_pkg::REC_ERROR);
    assign has_code = (result.error_code != stt_pkg::ERR_NONE);
    assign kind_ok = (result.record_kind == stt_pkg::REC_CONTENT) ||
                     (result.record_kind == stt_pkg::REC_TOKEN) || is_err;

    // a waiting record stays put until taken
    `STT_ASSERT_NEXT(a_hold, clk, rst_n, shown && !pop, shown && $stable(result), "record moved")
    `STT_ASSERT_ALWAYS(a_kind, clk, rst_n, !shown || kind_ok, "unknown record kind")
    // an error stops the run, so it is always its last record
    `STT_ASSERT_ALWAYS(a_err_last, clk, rst_n, !shown || !is_err || (has_code && result.last_of_run), "bad error")
    `STT_ASSERT_ALWAYS(a_no_err, clk, rst_n, !shown || is_err || !has_code, "error code on plain record")

endmodule

bind source_text_tokenizer stt_checker u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .pop(pop),
    .empty(empty),
    .result(result)
);
